// ----- rtl/rasmt_pkg.sv -----
`default_nettype none

package rasmt_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_ADD   = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [63:0] sum;
		logic [63:0] mn;
		logic [63:0] mx;
		logic [63:0] pend;
	} node_t;

	typedef enum logic [1:0] {
		RD_CUR   = 2'd0,
		RD_LEFT  = 2'd1,
		RD_RIGHT = 2'd2,
		RD_AP    = 2'd3
	} rd_sel_t;

	typedef enum logic [1:0] {
		AP_COVER = 2'd0,
		AP_LEFT  = 2'd1,
		AP_RIGHT = 2'd2
	} ap_sel_t;

	typedef enum logic [1:0] {
		WR_AP      = 2'd0,
		WR_LEAF    = 2'd1,
		WR_CLEAR   = 2'd2,
		WR_COMBINE = 2'd3
	} wr_sel_t;

	typedef struct packed {
		logic    start;
		logic    build;
		logic    load_wr;
		logic    desc_left;
		logic    desc_right;
		logic    pop;
		logic    node_rd;
		rd_sel_t rd_sel;
		logic    leaf_rd;
		logic    ap_setup;
		ap_sel_t ap_sel;
		logic    ap_m1;
		logic    ap_m2;
		logic    node_wr;
		wr_sel_t wr_sel;
		logic    par_latch;
		logic    tmp_latch;
		logic    acc_update;
		logic    res_load;
	} ctl_t;

	typedef struct packed {
		logic is_leaf;
		logic disjoint;
		logic covered;
		logic pend_zero;
		logic sp_zero;
		logic phase_right;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/rasmt_ctrl.sv -----
`default_nettype none

module rasmt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	input  wire logic [1:0]       command,
	input  wire rasmt_pkg::sts_t  sts,
	output logic                  cmd_stall,
	output rasmt_pkg::ctl_t       ctl
);
	import rasmt_pkg::*;

	typedef enum logic [19:0] {
		ST_IDLE     = 20'h00001,
		ST_VISIT    = 20'h00002,
		ST_LEAF_RD  = 20'h00004,
		ST_LEAF_WR  = 20'h00008,
		ST_COV_RD   = 20'h00010,
		ST_COV_ACC  = 20'h00020,
		ST_PUSH_RD  = 20'h00040,
		ST_PUSH_CHK = 20'h00080,
		ST_PUSH_R   = 20'h00100,
		ST_PUSH_CLR = 20'h00200,
		ST_DOWN_L   = 20'h00400,
		ST_RESUME   = 20'h00800,
		ST_CMB_RDL  = 20'h01000,
		ST_CMB_RDR  = 20'h02000,
		ST_CMB_WR   = 20'h04000,
		ST_AP_RD    = 20'h08000,
		ST_AP_M1    = 20'h10000,
		ST_AP_M2    = 20'h20000,
		ST_AP_WR    = 20'h40000,
		ST_RET      = 20'h80000
	} state_t;

	state_t state_q, state_d;
	state_t ap_ret_q, ap_ret_d;
	cmd_t   op_q, op_d;

	assign cmd_stall = (state_q != ST_IDLE);

	always_comb begin
		ctl      = '0;
		state_d  = state_q;
		ap_ret_d = ap_ret_q;
		op_d     = op_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					op_d = cmd_t'(command);
					unique case (cmd_t'(command))
						CMD_LOAD: ctl.load_wr = 1'b1;
						CMD_BUILD: begin
							ctl.start = 1'b1;
							ctl.build = 1'b1;
							state_d   = ST_VISIT;
						end
						default: begin
							ctl.start = 1'b1;
							state_d   = ST_VISIT;
						end
					endcase
				end
			end
			ST_VISIT: begin
				if (op_q == CMD_BUILD) begin
					state_d = sts.is_leaf ? ST_LEAF_RD : ST_DOWN_L;
				end else if (sts.disjoint) begin
					state_d = ST_RET;
				end else if (sts.covered) begin
					if (op_q == CMD_ADD) begin
						ctl.ap_setup = 1'b1;
						ctl.ap_sel   = AP_COVER;
						ap_ret_d     = ST_RET;
						state_d      = ST_AP_RD;
					end else begin
						state_d = ST_COV_RD;
					end
				end else begin
					state_d = ST_PUSH_RD;
				end
			end
			ST_LEAF_RD: begin
				ctl.leaf_rd = 1'b1;
				state_d     = ST_LEAF_WR;
			end
			ST_LEAF_WR: begin
				ctl.node_wr = 1'b1;
				ctl.wr_sel  = WR_LEAF;
				state_d     = ST_RET;
			end
			ST_COV_RD: begin
				ctl.node_rd = 1'b1;
				ctl.rd_sel  = RD_CUR;
				state_d     = ST_COV_ACC;
			end
			ST_COV_ACC: begin
				ctl.acc_update = 1'b1;
				state_d        = ST_RET;
			end
			ST_PUSH_RD: begin
				ctl.node_rd = 1'b1;
				ctl.rd_sel  = RD_CUR;
				state_d     = ST_PUSH_CHK;
			end
			ST_PUSH_CHK: begin
				ctl.par_latch = 1'b1;
				if (sts.pend_zero) begin
					state_d = ST_DOWN_L;
				end else begin
					ctl.ap_setup = 1'b1;
					ctl.ap_sel   = AP_LEFT;
					ap_ret_d     = ST_PUSH_R;
					state_d      = ST_AP_RD;
				end
			end
			ST_PUSH_R: begin
				ctl.ap_setup = 1'b1;
				ctl.ap_sel   = AP_RIGHT;
				ap_ret_d     = ST_PUSH_CLR;
				state_d      = ST_AP_RD;
			end
			ST_PUSH_CLR: begin
				ctl.node_wr = 1'b1;
				ctl.wr_sel  = WR_CLEAR;
				state_d     = ST_DOWN_L;
			end
			ST_DOWN_L: begin
				ctl.desc_left = 1'b1;
				state_d       = ST_VISIT;
			end
			ST_RESUME: begin
				if (!sts.phase_right) begin
					ctl.desc_right = 1'b1;
					state_d        = ST_VISIT;
				end else if (op_q == CMD_QUERY) begin
					state_d = ST_RET;
				end else begin
					state_d = ST_CMB_RDL;
				end
			end
			ST_CMB_RDL: begin
				ctl.node_rd = 1'b1;
				ctl.rd_sel  = RD_LEFT;
				state_d     = ST_CMB_RDR;
			end
			ST_CMB_RDR: begin
				ctl.tmp_latch = 1'b1;
				ctl.node_rd   = 1'b1;
				ctl.rd_sel    = RD_RIGHT;
				state_d       = ST_CMB_WR;
			end
			ST_CMB_WR: begin
				ctl.node_wr = 1'b1;
				ctl.wr_sel  = WR_COMBINE;
				state_d     = ST_RET;
			end
			ST_AP_RD: begin
				ctl.node_rd = 1'b1;
				ctl.rd_sel  = RD_AP;
				state_d     = ST_AP_M1;
			end
			ST_AP_M1: begin
				ctl.ap_m1 = 1'b1;
				state_d   = ST_AP_M2;
			end
			ST_AP_M2: begin
				ctl.ap_m2 = 1'b1;
				state_d   = ST_AP_WR;
			end
			ST_AP_WR: begin
				ctl.node_wr = 1'b1;
				ctl.wr_sel  = WR_AP;
				state_d     = ap_ret_q;
			end
			ST_RET: begin
				if (!sts.sp_zero) begin
					ctl.pop = 1'b1;
					state_d = ST_RESUME;
				end else if (op_q != CMD_QUERY) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					ctl.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ap_ret_q <= ST_RET;
			op_q     <= CMD_LOAD;
		end else begin
			state_q  <= state_d;
			ap_ret_q <= ap_ret_d;
			op_q     <= op_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rasmt_dp.sv -----
`default_nettype none

module rasmt_dp #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rasmt_pkg::ctl_t    ctl,
	output rasmt_pkg::sts_t         sts,
	input  wire logic [9:0]         element_index,
	input  wire logic signed [31:0] element_value,
	input  wire logic [9:0]         range_low,
	input  wire logic [9:0]         range_high,
	input  wire logic signed [63:0] add_amount,
	input  wire logic               cfg_we,
	input  wire logic [10:0]        cfg_data,
	input  wire logic               res_stall,
	output logic                    res_valid,
	output logic signed [63:0]      range_sum,
	output logic signed [63:0]      range_min,
	output logic signed [63:0]      range_max
);
	import rasmt_pkg::*;

	localparam int AW      = $clog2(MAX_ELEMENTS);
	localparam int NAW     = AW + 2;
	localparam int NODES   = 4 * MAX_ELEMENTS;
	localparam int CW      = $clog2(MAX_ELEMENTS + 1);
	localparam int IW      = (AW > 10) ? AW : 10;
	localparam int SD      = AW + 1;
	localparam int SPW     = $clog2(SD + 1);
	localparam int SIW     = $clog2(SD);
	localparam int RST_CNT = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;

	typedef struct packed {
		logic [NAW-1:0] node;
		logic [AW-1:0]  l;
		logic [AW-1:0]  r;
		logic           right;
	} frame_t;

	function automatic logic [63:0] s_min(input logic [63:0] a, input logic [63:0] b);
		return ($signed(b) < $signed(a)) ? b : a;
	endfunction

	function automatic logic [63:0] s_max(input logic [63:0] a, input logic [63:0] b);
		return ($signed(a) < $signed(b)) ? b : a;
	endfunction

	logic [10:0]    element_count_q;
	logic [AW-1:0]  tree_last_q;
	logic [9:0]     ql_q, qr_q;
	logic [63:0]    amt_q;
	logic [NAW-1:0] cur_node_q;
	logic [AW-1:0]  cur_l_q, cur_r_q;
	logic           cur_right_q;
	frame_t         stack_q [SD];
	logic [SPW-1:0] sp_q;

	node_t          node_mem [NODES];
	node_t          rdata_q;
	logic [31:0]    leaf_mem [MAX_ELEMENTS];
	logic [31:0]    leaf_rdata_q;
	node_t          par_q, tmp_q;

	logic [NAW-1:0] ap_addr_q;
	logic [63:0]    ap_amt_q;
	logic [CW-1:0]  ap_w_q;
	logic [63:0]    prod_lo_q, prod_q;

	logic [63:0]    acc_sum_q, acc_min_q, acc_max_q;
	logic           res_valid_q;
	logic [63:0]    res_sum_q, res_min_q, res_max_q;

	logic [AW-1:0]  mid;
	logic [NAW-1:0] left_node, right_node, rd_addr, wr_addr;
	logic [AW-1:0]  new_last;
	logic [SPW-1:0] sp_m1;
	frame_t         top;
	node_t          wr_data;
	logic [63:0]    leaf_ext;
	logic [32+CW-1:0] lo_mul, hi_mul;
	logic [CW-1:0]  w_cover, w_left, w_right;

	assign mid        = cur_l_q + ((cur_r_q - cur_l_q) >> 1);
	assign left_node  = {cur_node_q[NAW-2:0], 1'b0};
	assign right_node = {cur_node_q[NAW-2:0], 1'b1};
	assign sp_m1      = sp_q - 1'b1;
	assign top        = stack_q[sp_m1[SIW-1:0]];
	assign leaf_ext   = {{32{leaf_rdata_q[31]}}, leaf_rdata_q};

	assign w_cover = CW'(cur_r_q) - CW'(cur_l_q) + CW'(1);
	assign w_left  = CW'(mid) - CW'(cur_l_q) + CW'(1);
	assign w_right = CW'(cur_r_q) - CW'(mid);

	assign lo_mul = ap_amt_q[31:0] * ap_w_q;
	assign hi_mul = ap_amt_q[63:32] * ap_w_q;

	always_comb begin
		if (element_count_q == 11'd0) begin
			new_last = '0;
		end else if (32'(element_count_q) > MAX_ELEMENTS) begin
			new_last = AW'(MAX_ELEMENTS - 1);
		end else begin
			new_last = AW'(element_count_q - 11'd1);
		end
	end

	always_comb begin
		case (ctl.rd_sel)
			RD_LEFT:  rd_addr = left_node;
			RD_RIGHT: rd_addr = right_node;
			RD_AP:    rd_addr = ap_addr_q;
			default:  rd_addr = cur_node_q;
		endcase
	end

	always_comb begin
		wr_addr = cur_node_q;
		case (ctl.wr_sel)
			WR_AP: begin
				wr_addr = ap_addr_q;
				wr_data = '{sum: tmp_q.sum + prod_q, mn: tmp_q.mn + ap_amt_q,
					mx: tmp_q.mx + ap_amt_q, pend: tmp_q.pend + ap_amt_q};
			end
			WR_LEAF:  wr_data = '{sum: leaf_ext, mn: leaf_ext, mx: leaf_ext, pend: 64'd0};
			WR_CLEAR: wr_data = '{sum: par_q.sum, mn: par_q.mn, mx: par_q.mx, pend: 64'd0};
			default: begin
				wr_data = '{sum: tmp_q.sum + rdata_q.sum, mn: s_min(tmp_q.mn, rdata_q.mn),
					mx: s_max(tmp_q.mx, rdata_q.mx), pend: 64'd0};
			end
		endcase
	end

	always_comb begin
		sts.is_leaf     = (cur_l_q == cur_r_q);
		sts.disjoint    = (IW'(ql_q) > IW'(cur_r_q)) || (IW'(qr_q) < IW'(cur_l_q));
		sts.covered     = (IW'(ql_q) <= IW'(cur_l_q)) && (IW'(qr_q) >= IW'(cur_r_q));
		sts.pend_zero   = (rdata_q.pend == 64'd0);
		sts.sp_zero     = (sp_q == '0);
		sts.phase_right = cur_right_q;
		sts.out_free    = !res_valid_q || !res_stall;
	end

	// memories
	always_ff @(posedge clk) begin
		if (ctl.node_wr) begin
			node_mem[wr_addr] <= wr_data;
		end
		if (ctl.node_rd) begin
			rdata_q <= node_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_wr && (32'(element_index) < MAX_ELEMENTS)) begin
			leaf_mem[AW'(element_index)] <= element_value;
		end
		if (ctl.leaf_rd) begin
			leaf_rdata_q <= leaf_mem[cur_l_q];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= 11'd1024;
			tree_last_q     <= AW'(RST_CNT - 1);
			sp_q            <= '0;
			res_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				element_count_q <= cfg_data;
			end
			if (ctl.start && ctl.build) begin
				tree_last_q <= new_last;
			end
			if (ctl.start) begin
				sp_q <= '0;
			end else if (ctl.desc_left || ctl.desc_right) begin
				sp_q <= sp_q + 1'b1;
			end else if (ctl.pop) begin
				sp_q <= sp_m1;
			end
			if (ctl.res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// traversal payload
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			ql_q        <= range_low;
			qr_q        <= range_high;
			amt_q       <= add_amount;
			cur_node_q  <= NAW'(1);
			cur_l_q     <= '0;
			cur_r_q     <= ctl.build ? new_last : tree_last_q;
			cur_right_q <= 1'b0;
			acc_sum_q   <= 64'd0;
			acc_min_q   <= MOST_POS;
			acc_max_q   <= MOST_NEG;
		end
		if (ctl.desc_left) begin
			stack_q[sp_q[SIW-1:0]] <= '{node: cur_node_q, l: cur_l_q, r: cur_r_q, right: 1'b0};
			cur_node_q <= left_node;
			cur_r_q    <= mid;
		end
		if (ctl.desc_right) begin
			stack_q[sp_q[SIW-1:0]] <= '{node: cur_node_q, l: cur_l_q, r: cur_r_q, right: 1'b1};
			cur_node_q <= right_node;
			cur_l_q    <= mid + 1'b1;
		end
		if (ctl.pop) begin
			cur_node_q  <= top.node;
			cur_l_q     <= top.l;
			cur_r_q     <= top.r;
			cur_right_q <= top.right;
		end
		if (ctl.par_latch) begin
			par_q <= rdata_q;
		end
		if (ctl.tmp_latch || ctl.ap_m1) begin
			tmp_q <= rdata_q;
		end
		if (ctl.ap_setup) begin
			case (ctl.ap_sel)
				AP_LEFT: begin
					ap_addr_q <= left_node;
					ap_amt_q  <= rdata_q.pend;
					ap_w_q    <= w_left;
				end
				AP_RIGHT: begin
					ap_addr_q <= right_node;
					ap_amt_q  <= par_q.pend;
					ap_w_q    <= w_right;
				end
				default: begin
					ap_addr_q <= cur_node_q;
					ap_amt_q  <= amt_q;
					ap_w_q    <= w_cover;
				end
			endcase
		end
		// width times amount in two 32-bit halves
		if (ctl.ap_m1) begin
			prod_lo_q <= 64'(lo_mul);
		end
		if (ctl.ap_m2) begin
			prod_q <= prod_lo_q + {hi_mul[31:0], 32'd0};
		end
		if (ctl.acc_update) begin
			acc_sum_q <= acc_sum_q + rdata_q.sum;
			acc_min_q <= s_min(acc_min_q, rdata_q.mn);
			acc_max_q <= s_max(acc_max_q, rdata_q.mx);
		end
		if (ctl.res_load) begin
			res_sum_q <= acc_sum_q;
			res_min_q <= acc_min_q;
			res_max_q <= acc_max_q;
		end
	end

	assign res_valid = res_valid_q;
	assign range_sum = res_sum_q;
	assign range_min = res_min_q;
	assign range_max = res_max_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(SD)) else $error("stack pointer past depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> sp_q != '0) else $error("pop of empty stack");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.desc_left || ctl.desc_right) |-> sp_q < SPW'(SD)) else $error("stack overflow");
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_load |-> (!res_valid_q || !res_stall)) else $error("result overwritten");

endmodule

`default_nettype wire

// ----- rtl/range_add_sum_min_max_tree.sv -----
// Lazy segment tree: range add, range sum / min / max query.
// Command channel: cmd_valid / cmd_stall with command, element_index,
// element_value, range_low, range_high, add_amount. Result channel:
// res_valid / res_stall with range_sum, range_min, range_max; only a
// query produces a result item.
// element_count is written through cfg_we / cfg_data; the user must write
// it only while idle, as the block itself does not enforce it. It is latched
// into the tree by the next build. A load is taken without a stall and
// the next item may follow at once. Build, add and query walk the tree
// one node at a time through a single node memory port; an add or query
// visits up to four nodes per level. A query result is registered once
// its walk ends and the result register is free.
// The result register holds one item; a new command is taken while it
// waits, but a later query cannot finish its walk until the result is
// taken, and further commands stall meanwhile.
// Reset clears control state and sets element_count to 1024; leaves and
// tree contents are undefined until loaded and built.
`default_nettype none

module range_add_sum_min_max_tree #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic [1:0]         command,
	input  wire logic [9:0]         element_index,
	input  wire logic signed [31:0] element_value,
	input  wire logic [9:0]         range_low,
	input  wire logic [9:0]         range_high,
	input  wire logic signed [63:0] add_amount,
	input  wire logic               cfg_we,
	input  wire logic [10:0]        cfg_data,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic signed [63:0]      range_sum,
	output logic signed [63:0]      range_min,
	output logic signed [63:0]      range_max
);
	import rasmt_pkg::*;

	ctl_t ctl;
	sts_t sts;

	rasmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (command),
		.sts       (sts),
		.cmd_stall (cmd_stall),
		.ctl       (ctl)
	);

	rasmt_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.element_index (element_index),
		.element_value (element_value),
		.range_low     (range_low),
		.range_high    (range_high),
		.add_amount    (add_amount),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.res_stall     (res_stall),
		.res_valid     (res_valid),
		.range_sum     (range_sum),
		.range_min     (range_min),
		.range_max     (range_max)
	);

endmodule

`default_nettype wire
